### rtl/ggfn_pkg.sv
package ggfn_pkg;

	localparam int ExpTableDepth = 256;

	typedef enum logic [2:0] {
		MODE_VISUAL = 3'd0,
		MODE_EYE    = 3'd1,
		MODE_GAUSS  = 3'd2,
		MODE_DGAUSS = 3'd3,
		MODE_SIGM   = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE    = 3'd0,
		REG_VPREF   = 3'd1,
		REG_EPREF   = 3'd2,
		REG_E2PREF  = 3'd3,
		REG_GAIN2   = 3'd4,
		REG_INVW    = 3'd5,
		REG_SLOPE   = 3'd6
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_G1_SQ,
		ST_G1_SCALE,
		ST_G2_SQ,
		ST_G2_SCALE,
		ST_DG_MIX,
		ST_SG_MUL,
		ST_SG_START,
		ST_SG_DIV,
		ST_VIS_SQ,
		ST_VIS_SCALE,
		ST_COMBINE,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SQ,
		OP_SCALE,
		OP_MIX,
		OP_SGMUL,
		OP_PROD
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] sel_ref;
		logic       ld_g1;
		logic       ld_eye;
		logic       ld_eye_sig;
		logic       div_start;
		logic       upd_best;
		logic       clr_best;
		logic       ld_out;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} sts_t;

	localparam logic [1:0] REF_EYE  = 2'd0;
	localparam logic [1:0] REF_EYE2 = 2'd1;
	localparam logic [1:0] REF_VIS  = 2'd2;

	function automatic logic [15:0] exp_entry(input int k);
		logic [63:0] e;
		logic [63:0] p;
		e = 64'h1_0000_0000;
		for (int i = 0; i < k; i++) begin
			p = e * 64'd4034748387 + 64'h8000_0000;
			e = p >> 32;
		end
		return 16'((e + 64'h1_0000) >> 17);
	endfunction

endpackage

### rtl/ggfn_div.sv
module ggfn_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] num,
	input  logic [16:0] den,
	output logic [15:0] quo,
	output logic        done
);
	logic [31:0] n_q;
	logic [16:0] r_q;
	logic [15:0] qv_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [17:0] trial;

	assign trial = {r_q, n_q[31]} - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q  <= num;
			r_q  <= '0;
			qv_q <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[30:0], 1'b0};
			if (!trial[17]) begin
				r_q  <= trial[16:0];
				qv_q <= {qv_q[14:0], 1'b1};
			end else begin
				r_q  <= {r_q[15:0], n_q[31]};
				qv_q <= {qv_q[14:0], 1'b0};
			end
		end
	end

	assign quo = qv_q;
endmodule

### rtl/ggfn_datapath.sv
module ggfn_datapath #(
	parameter int EXP_TABLE_DEPTH = ggfn_pkg::ExpTableDepth
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ggfn_pkg::cmd_t    cmd,
	output ggfn_pkg::sts_t    sts,
	input  logic              in_ld,
	input  logic signed [15:0] position,
	input  logic [2:0]        mode,
	input  logic signed [15:0] vis_pref,
	input  logic signed [15:0] eye_pref,
	input  logic signed [15:0] eye2_pref,
	input  logic [15:0]       gain2,
	input  logic [15:0]       inv_w,
	input  logic signed [15:0] slope,
	output logic [15:0]       rate
);
	logic [15:0] exp_rom [EXP_TABLE_DEPTH];
	for (genvar k = 0; k < EXP_TABLE_DEPTH; k++) begin : g_rom
		assign exp_rom[k] = ggfn_pkg::exp_entry(k);
	end

	logic signed [15:0] pos_q;
	logic [33:0] acc_q;
	logic [15:0] g1_q, g2_q, eye_q, best_q, g_now;
	logic signed [15:0] refv;
	logic signed [16:0] d;
	logic [16:0] m;
	logic [33:0] sq;
	logic [49:0] sc;
	logic [49:0] mul;
	logic [33:0] x;
	logic [15:0] t_q;
	logic        yneg_q;
	logic [32:0] ys;
	logic [32:0] ym;
	logic [16:0] den;
	logic [31:0] num;
	logic [15:0] quo;
	logic        div_done;
	logic [17:0] mix;
	logic [32:0] prod;

	always_comb begin
		case (cmd.sel_ref)
			ggfn_pkg::REF_EYE:  refv = eye_pref;
			ggfn_pkg::REF_EYE2: refv = eye2_pref;
			default:            refv = vis_pref;
		endcase
	end

	assign d  = 17'(pos_q) - 17'(refv);
	assign m  = d[16] ? 17'(-d) : d;
	assign sq = 34'(m) * 34'(m);
	assign sc = 50'(acc_q) * 50'(inv_w);
	assign ys = 33'(slope) * 33'(d);
	assign ym = ys[32] ? 33'(-ys) : ys;
	assign x  = 34'(sc >> 20);

	always_comb begin
		g_now = '0;
		if (x < 34'(EXP_TABLE_DEPTH))
			g_now = exp_rom[x[$clog2(EXP_TABLE_DEPTH)-1:0]];
	end

	assign mul  = 50'(gain2) * 50'(g2_q);
	assign mix  = 18'(g1_q) + 18'((mul + 50'd32768) >> 16);
	assign prod = 33'((34'(best_q) * 34'(eye_q) + 34'd16384) >> 15);

	logic [15:0] t_now;
	always_comb begin
		t_now = '0;
		if ((ym >> 12) < 33'(EXP_TABLE_DEPTH))
			t_now = exp_rom[ym[12 +: $clog2(EXP_TABLE_DEPTH)]];
	end

	assign den = 17'd32768 + 17'(t_q);
	assign num = (yneg_q ? 32'h4000_0000 : {1'b0, t_q, 15'd0}) + 32'(den >> 1);

	ggfn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (num),
		.den   (den),
		.quo   (quo),
		.done  (div_done)
	);
	assign sts.div_done = div_done;

	always_ff @(posedge clk) begin
		if (in_ld)
			pos_q <= position;
		case (cmd.op)
			ggfn_pkg::OP_SQ:    acc_q <= sq;
			ggfn_pkg::OP_SCALE: g2_q  <= g_now;
			ggfn_pkg::OP_SGMUL: begin
				t_q    <= t_now;
				yneg_q <= ys[32];
			end
			default: ;
		endcase
		if (cmd.ld_g1)
			g1_q <= g_now;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eye_q  <= '0;
			best_q <= '0;
			rate   <= '0;
		end else begin
			if (cmd.ld_eye) begin
				if (cmd.op == ggfn_pkg::OP_MIX)
					eye_q <= mix[17:16] != 2'd0 ? 16'hFFFF : mix[15:0];
				else if (mode == ggfn_pkg::MODE_EYE || mode == ggfn_pkg::MODE_GAUSS)
					eye_q <= g_now;
				else
					eye_q <= '0;
			end
			if (cmd.ld_eye_sig)
				eye_q <= quo;
			if (cmd.clr_best)
				best_q <= '0;
			else if (cmd.upd_best && g_now > best_q)
				best_q <= g_now;
			if (cmd.ld_out) begin
				case (mode)
					ggfn_pkg::MODE_VISUAL: rate <= best_q;
					ggfn_pkg::MODE_EYE:    rate <= eye_q;
					ggfn_pkg::MODE_GAUSS, ggfn_pkg::MODE_DGAUSS, ggfn_pkg::MODE_SIGM:
						rate <= prod[32:16] != 17'd0 ? 16'hFFFF : prod[15:0];
					default: rate <= '0;
				endcase
			end
		end
	end
endmodule

### rtl/ggfn_ctrl.sv
module ggfn_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           in_last,
	input  logic [2:0]     mode,
	output logic           in_ld,
	output logic           out_valid,
	input  logic           out_stall,
	output ggfn_pkg::cmd_t cmd,
	input  ggfn_pkg::sts_t sts
);
	ggfn_pkg::state_t st_q, st_d;
	logic await_q, last_q, ovalid_q;
	logic acc;

	assign in_stall  = (st_q != ggfn_pkg::ST_IDLE) || (ovalid_q && out_stall);
	assign acc       = in_valid && !in_stall;
	assign in_ld     = acc;
	assign out_valid = ovalid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ggfn_pkg::ST_IDLE;
			await_q  <= 1'b1;
			last_q   <= 1'b0;
			ovalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (acc)
				last_q <= in_last;
			if (ovalid_q && !out_stall)
				ovalid_q <= 1'b0;
			if (st_q == ggfn_pkg::ST_OUT) begin
				ovalid_q <= 1'b1;
				await_q  <= 1'b1;
			end
			if (acc && await_q)
				await_q <= 1'b0;
		end
	end

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		cmd.sel_ref = ggfn_pkg::REF_EYE;
		case (st_q)
			ggfn_pkg::ST_IDLE:
				if (acc) begin
					if (!await_q)
						st_d = ggfn_pkg::ST_VIS_SQ;
					else if (mode == ggfn_pkg::MODE_SIGM)
						st_d = ggfn_pkg::ST_SG_MUL;
					else
						st_d = ggfn_pkg::ST_G1_SQ;
				end
			ggfn_pkg::ST_G1_SQ: begin
				cmd.op = ggfn_pkg::OP_SQ;
				st_d   = ggfn_pkg::ST_G1_SCALE;
			end
			ggfn_pkg::ST_G1_SCALE: begin
				cmd.clr_best = 1'b1;
				if (mode == ggfn_pkg::MODE_DGAUSS) begin
					cmd.ld_g1 = 1'b1;
					st_d      = ggfn_pkg::ST_G2_SQ;
				end else begin
					cmd.ld_eye = 1'b1;
					st_d = last_q ? ggfn_pkg::ST_COMBINE : ggfn_pkg::ST_IDLE;
				end
			end
			ggfn_pkg::ST_G2_SQ: begin
				cmd.op      = ggfn_pkg::OP_SQ;
				cmd.sel_ref = ggfn_pkg::REF_EYE2;
				st_d        = ggfn_pkg::ST_G2_SCALE;
			end
			ggfn_pkg::ST_G2_SCALE: begin
				cmd.op = ggfn_pkg::OP_SCALE;
				st_d   = ggfn_pkg::ST_DG_MIX;
			end
			ggfn_pkg::ST_DG_MIX: begin
				cmd.op     = ggfn_pkg::OP_MIX;
				cmd.ld_eye = 1'b1;
				st_d = last_q ? ggfn_pkg::ST_COMBINE : ggfn_pkg::ST_IDLE;
			end
			ggfn_pkg::ST_SG_MUL: begin
				cmd.op       = ggfn_pkg::OP_SGMUL;
				cmd.clr_best = 1'b1;
				st_d         = ggfn_pkg::ST_SG_START;
			end
			ggfn_pkg::ST_SG_START: begin
				cmd.div_start = 1'b1;
				st_d          = ggfn_pkg::ST_SG_DIV;
			end
			ggfn_pkg::ST_SG_DIV:
				if (sts.div_done) begin
					cmd.ld_eye_sig = 1'b1;
					st_d = last_q ? ggfn_pkg::ST_COMBINE : ggfn_pkg::ST_IDLE;
				end
			ggfn_pkg::ST_VIS_SQ: begin
				cmd.op      = ggfn_pkg::OP_SQ;
				cmd.sel_ref = ggfn_pkg::REF_VIS;
				st_d        = ggfn_pkg::ST_VIS_SCALE;
			end
			ggfn_pkg::ST_VIS_SCALE: begin
				cmd.upd_best = 1'b1;
				st_d = last_q ? ggfn_pkg::ST_COMBINE : ggfn_pkg::ST_IDLE;
			end
			ggfn_pkg::ST_COMBINE: begin
				cmd.ld_out = 1'b1;
				st_d       = ggfn_pkg::ST_OUT;
			end
			ggfn_pkg::ST_OUT:
				st_d = ggfn_pkg::ST_IDLE;
			default:
				st_d = ggfn_pkg::ST_IDLE;
		endcase
	end
endmodule

### rtl/gaussian_gain_field_neuron_rate_core.sv
// channel | signals                          | direction
// in      | valid, stall, position, last     | item into block
// out     | out_valid, out_stall, firing_rate| rate out, one per sample
// cfg     | cfg_we, cfg_index, cfg_data      | register writes
// Retinal item: square, then scale + table + update; last item: combine, out.
// Gaussian eye item: square, scale; double Gaussian: both twice, then mix;
// sigmoid: multiply, 32-step restoring divider. Input is stalled while a
// sample item is at work or while a finished rate waits under out_stall.
// Async reset: mode 2, inverse width 1.0, slope 1.0, expecting an eye item.
module gaussian_gain_field_neuron_rate_core #(
	parameter int EXP_TABLE_DEPTH = ggfn_pkg::ExpTableDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid,
	output logic               stall,
	input  logic signed [15:0] position,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        firing_rate,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);
	logic [2:0]  mode_q;
	logic signed [15:0] vpref_q, epref_q, e2pref_q, slope_q;
	logic [15:0] gain2_q, invw_q;
	logic in_ld;
	ggfn_pkg::cmd_t cmd;
	ggfn_pkg::sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ggfn_pkg::MODE_GAUSS;
			vpref_q  <= '0;
			epref_q  <= '0;
			e2pref_q <= '0;
			gain2_q  <= '0;
			invw_q   <= 16'd256;
			slope_q  <= 16'sd256;
		end else if (cfg_we) begin
			case (cfg_index)
				ggfn_pkg::REG_MODE:   mode_q   <= cfg_data[2:0];
				ggfn_pkg::REG_VPREF:  vpref_q  <= cfg_data;
				ggfn_pkg::REG_EPREF:  epref_q  <= cfg_data;
				ggfn_pkg::REG_E2PREF: e2pref_q <= cfg_data;
				ggfn_pkg::REG_GAIN2:  gain2_q  <= cfg_data;
				ggfn_pkg::REG_INVW:   invw_q   <= cfg_data;
				ggfn_pkg::REG_SLOPE:  slope_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	ggfn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid),
		.in_stall (stall),
		.in_last  (last),
		.mode     (mode_q),
		.in_ld    (in_ld),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cmd      (cmd),
		.sts      (sts)
	);

	ggfn_datapath #(.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_ld    (in_ld),
		.position (position),
		.mode     (mode_q),
		.vis_pref (vpref_q),
		.eye_pref (epref_q),
		.eye2_pref(e2pref_q),
		.gain2    (gain2_q),
		.inv_w    (invw_q),
		.slope    (slope_q),
		.rate     (firing_rate)
	);
endmodule
